### hdl/bpfm_pkg.sv
package bpfm_pkg;

	localparam int POOL_SIZE = 16;
	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam int TAG_W = 32;
	localparam int PIN_W = 16;

	localparam logic [TAG_W-1:0] PAGE_INVALID = '1;
	localparam logic [PIN_W-1:0] PIN_MAX = '1;

	localparam logic [2:0] K_FETCH = 3'd0;
	localparam logic [2:0] K_NEW = 3'd1;
	localparam logic [2:0] K_UNPIN = 3'd2;
	localparam logic [2:0] K_FLUSH = 3'd3;
	localparam logic [2:0] K_FLUSHALL = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic signed [31:0] page_id;
		logic dirty_flag;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] frame;
		logic [1:0] disk_op;
		logic signed [31:0] disk_page;
		logic last;
	} res_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_HIT,
		C_INSTALL,
		C_UNPIN,
		C_FLUSH
	} cell_op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t op;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] page;
		logic dflag;
		logic rm_en;
		logic [IDX_W-1:0] rm_rank;
		logic [IDX_W-1:0] add_rank;
		logic start;
		logic scan_adv;
	} cell_cmd_t;

	typedef struct packed {
		logic match;
		logic valid;
		logic dirty;
		logic pin_zero;
		logic member;
		logic [IDX_W-1:0] rank;
		logic [TAG_W-1:0] tag;
		logic tok;
		logic want;
	} cell_st_t;

endpackage

### hdl/buffer_pool_frame_manager.sv
// channel | signals                  | direction | payload
// req     | req_valid, req_stall     | in        | req_t kind, page_id, dirty_flag
// res     | res_valid, res_stall     | out       | res_t status, frame, disk_op, disk_page, last
// one request at a time: accept, tag compare in the cells, decide, then emit
// answer only (hit, unpin, refused, pool full): the answer item alone; a disk item goes
// before it, and an eviction write-back before the disk item
// flush all: a token walks through every cell; write-backs go out as it passes
// reset clears all frames at once; no clearing pass
// a stalled result holds the emit state; the cells wait with it
module buffer_pool_frame_manager
	import bpfm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	cell_cmd_t cmd;
	cell_st_t cst [POOL_SIZE];
	logic [POOL_SIZE:0] tok;
	logic [POOL_SIZE-1:0] tok_vec;
	logic [POOL_SIZE-1:0] vic_vec;

	assign tok[0] = cmd.start;

	for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
		bpfm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.my_idx(IDX_W'(g)),
			.cmd(cmd),
			.tok_in(tok[g]),
			.tok_out(tok[g+1]),
			.st(cst[g])
		);
		assign tok_vec[g] = cst[g].tok;
		assign vic_vec[g] = cst[g].member && (cst[g].rank == '0);
	end

	bpfm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cst(cst),
		.scan_end(tok[POOL_SIZE]),
		.cmd(cmd)
	);

	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan token in the chain");

	a_lru_head: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vic_vec))
		else $error("two frames hold the oldest lru rank");

endmodule

### hdl/bpfm_cell.sv
module bpfm_cell
	import bpfm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [IDX_W-1:0] my_idx,
	input  cell_cmd_t cmd,
	input  logic tok_in,
	output logic tok_out,
	output cell_st_t st
);

	logic [TAG_W-1:0] tag_q;
	logic valid_q;
	logic dirty_q;
	logic [PIN_W-1:0] pin_q;
	logic member_q;
	logic [IDX_W-1:0] rank_q;
	logic tok_q;
	logic sel;
	logic want;

	assign sel = (cmd.idx == my_idx);
	assign want = tok_q && valid_q && dirty_q && (tag_q != PAGE_INVALID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			pin_q <= '0;
			member_q <= 1'b0;
			rank_q <= '0;
			tok_q <= 1'b0;
		end else begin
			if (cmd.start || cmd.scan_adv) begin
				tok_q <= tok_in;
			end
			if (want && cmd.scan_adv) begin
				dirty_q <= 1'b0;
			end
			// close the gap left by a frame leaving the lru order
			if (cmd.rm_en && member_q && rank_q > cmd.rm_rank) begin
				rank_q <= rank_q - IDX_W'(1);
			end
			if (sel) begin
				case (cmd.op)
					C_HIT: begin
						member_q <= 1'b0;
						rank_q <= '0;
						if (pin_q != PIN_MAX) begin
							pin_q <= pin_q + PIN_W'(1);
						end
					end
					C_INSTALL: begin
						member_q <= 1'b0;
						rank_q <= '0;
						pin_q <= PIN_W'(1);
						tag_q <= cmd.page;
						valid_q <= 1'b1;
						dirty_q <= 1'b0;
					end
					C_UNPIN: begin
						if (cmd.dflag) begin
							dirty_q <= 1'b1;
						end
						if (pin_q != '0) begin
							pin_q <= pin_q - PIN_W'(1);
							if (pin_q == PIN_W'(1) && !member_q) begin
								member_q <= 1'b1;
								rank_q <= cmd.add_rank;
							end
						end
					end
					C_FLUSH: begin
						dirty_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign tok_out = tok_q;
	assign st.match = valid_q && (tag_q == cmd.page);
	assign st.valid = valid_q;
	assign st.dirty = dirty_q;
	assign st.pin_zero = (pin_q == '0);
	assign st.member = member_q;
	assign st.rank = rank_q;
	assign st.tag = tag_q;
	assign st.tok = tok_q;
	assign st.want = want;

endmodule

### hdl/bpfm_ctrl.sv
module bpfm_ctrl
	import bpfm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res,
	input  cell_st_t cst [POOL_SIZE],
	input  logic scan_end,
	output cell_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_SCAN,
		S_WB,
		S_DISK,
		S_ANS
	} state_t;

	state_t state_q;
	logic [2:0] kind_q;
	logic [TAG_W-1:0] page_q;
	logic dflag_q;
	logic hit_q;
	logic [IDX_W-1:0] idx_q;
	logic vic_q;
	logic [IDX_W-1:0] vidx_q;
	logic unp_q;
	logic [CNT_W-1:0] free_q;
	logic [TAG_W-1:0] wb_tag_q;
	logic op_pend_q;
	logic [1:0] op_q;
	logic [1:0] st_q;
	logic [IDX_W-1:0] frame_q;
	logic res_valid_q;
	res_t res_q;

	logic slot_free;
	logic emit_c;
	logic hit_c;
	logic [IDX_W-1:0] idx_c;
	logic vic_c;
	logic [IDX_W-1:0] vidx_c;
	logic unp_c;
	logic want_any;
	logic [TAG_W-1:0] scan_tag;
	logic [POOL_SIZE-1:0] member_vec;

	logic [IDX_W-1:0] tgt;
	logic d_wb;
	logic d_op_pend;
	logic [1:0] d_op;
	logic [1:0] d_st;
	logic [IDX_W-1:0] d_frame;
	logic d_free_dec;
	logic d_scan;

	assign slot_free = !res_valid_q || !res_stall;

	// a result item is loaded in this cycle
	assign emit_c = slot_free && ((state_q == S_SCAN && want_any) || state_q == S_WB ||
		state_q == S_DISK || state_q == S_ANS);

	// lowest index wins on a tag match, as for the victim
	always_comb begin
		hit_c = 1'b0;
		idx_c = '0;
		vic_c = 1'b0;
		vidx_c = '0;
		unp_c = 1'b0;
		want_any = 1'b0;
		scan_tag = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (cst[i].match) begin
				hit_c = 1'b1;
				idx_c = IDX_W'(i);
			end
			if (cst[i].member && cst[i].rank == '0) begin
				vic_c = 1'b1;
				vidx_c = IDX_W'(i);
			end
			if (cst[i].pin_zero) begin
				unp_c = 1'b1;
			end
			if (cst[i].want) begin
				want_any = 1'b1;
				scan_tag = scan_tag | cst[i].tag;
			end
			member_vec[i] = cst[i].member;
		end
	end

	assign tgt = (free_q != '0) ? IDX_W'(free_q - CNT_W'(1)) : vidx_q;

	always_comb begin
		cmd = '0;
		cmd.op = C_NONE;
		cmd.page = page_q;
		cmd.dflag = dflag_q;
		cmd.add_rank = IDX_W'($countones(member_vec));
		cmd.scan_adv = (state_q == S_SCAN) && (!want_any || slot_free);
		d_wb = 1'b0;
		d_op_pend = 1'b0;
		d_op = OP_NONE;
		d_st = ST_REFUSED;
		d_frame = '0;
		d_free_dec = 1'b0;
		d_scan = 1'b0;
		if (state_q == S_DECIDE) begin
			case (kind_q)
				K_FETCH, K_NEW: begin
					if (kind_q == K_FETCH && hit_q) begin
						cmd.op = C_HIT;
						cmd.idx = idx_q;
						cmd.rm_en = cst[idx_q].member;
						cmd.rm_rank = cst[idx_q].rank;
						d_st = ST_OK;
						d_frame = idx_q;
					end else if ((kind_q == K_NEW && !unp_q) ||
							(free_q == '0 && !vic_q)) begin
						d_st = ST_FULL;
					end else begin
						cmd.op = C_INSTALL;
						cmd.idx = tgt;
						cmd.rm_en = cst[tgt].member;
						cmd.rm_rank = cst[tgt].rank;
						d_wb = (free_q == '0) && cst[tgt].valid && cst[tgt].dirty;
						d_free_dec = (free_q != '0);
						d_op_pend = 1'b1;
						d_op = (kind_q == K_FETCH) ? OP_READ : OP_WRITE;
						d_st = ST_OK;
						d_frame = tgt;
					end
				end
				K_UNPIN: begin
					if (hit_q) begin
						cmd.op = C_UNPIN;
						cmd.idx = idx_q;
						d_st = cst[idx_q].pin_zero ? ST_REFUSED : ST_OK;
					end
				end
				K_FLUSH: begin
					if (hit_q && page_q != PAGE_INVALID && cst[idx_q].dirty) begin
						cmd.op = C_FLUSH;
						cmd.idx = idx_q;
						d_op_pend = 1'b1;
						d_op = OP_WRITE;
						d_st = ST_OK;
					end
				end
				K_FLUSHALL: begin
					cmd.start = 1'b1;
					d_scan = 1'b1;
					d_st = ST_OK;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q <= CNT_W'(POOL_SIZE);
			res_valid_q <= 1'b0;
			hit_q <= 1'b0;
			vic_q <= 1'b0;
			unp_q <= 1'b0;
			op_pend_q <= 1'b0;
		end else begin
			if (emit_c) begin
				res_valid_q <= 1'b1;
			end else if (slot_free) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q <= req.kind;
						page_q <= req.page_id;
						dflag_q <= req.dirty_flag;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q <= hit_c;
					idx_q <= idx_c;
					vic_q <= vic_c;
					vidx_q <= vidx_c;
					unp_q <= unp_c;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					wb_tag_q <= cst[tgt].tag;
					op_pend_q <= d_op_pend;
					op_q <= d_op;
					st_q <= d_st;
					frame_q <= d_frame;
					if (d_free_dec) begin
						free_q <= free_q - CNT_W'(1);
					end
					if (d_scan) begin
						state_q <= S_SCAN;
					end else if (d_wb) begin
						state_q <= S_WB;
					end else if (d_op_pend) begin
						state_q <= S_DISK;
					end else begin
						state_q <= S_ANS;
					end
				end
				S_SCAN: begin
					if (want_any && slot_free) begin
						res_q <= '{ST_OK, 4'd0, OP_WRITE, scan_tag, 1'b0};
					end
					if (cmd.scan_adv && scan_end) begin
						state_q <= S_ANS;
					end
				end
				S_WB: begin
					if (slot_free) begin
						res_q <= '{ST_OK, 4'd0, OP_WRITE, wb_tag_q, 1'b0};
						state_q <= op_pend_q ? S_DISK : S_ANS;
					end
				end
				S_DISK: begin
					if (slot_free) begin
						res_q <= '{ST_OK, 4'd0, op_q, page_q, 1'b0};
						state_q <= S_ANS;
					end
				end
				S_ANS: begin
					if (slot_free) begin
						res_q <= '{st_q, 4'(frame_q), OP_NONE, 32'sd0, 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(POOL_SIZE))
		else $error("free count above pool size");

	a_wb_only_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && d_wb) |-> (free_q == '0 && vic_q))
		else $error("write-back without an eviction");

endmodule
